>>> src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	localparam logic [7:0] CH_TAB          = 8'h09;
	localparam logic [7:0] CH_LF           = 8'h0A;
	localparam logic [7:0] CH_CR           = 8'h0D;
	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] BLANK_CHAR      = 8'h20;
	localparam logic [7:0] RESET_ATTR      = 8'h07;
	localparam logic [15:0] BLANK_CELL     = {RESET_ATTR, BLANK_CHAR};
	localparam int TAB_SHIFT               = 3;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic write;
		logic scroll;
	} cursor_step_t;

endpackage

`default_nettype wire

>>> src/text_console_writer_unit.sv
// After an item is accepted, the result register loads in ST_RESP once the output is not held
// off, and input is taken again in ST_IDLE only after that, so items do not overlap.
// A put that scrolls first adds a pass over the store in ST_SCROLL, one entry copied per cycle
// through one read port and one write port; the bottom row is blanked with the current attribute.
// Asynchronous reset clears the cursor and the control state and sets the attribute register to
// 0x07; a clearing pass then writes a blank cell to every entry of the store.
`default_nettype none

module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [7:0]  char_code,
	input  wire logic [10:0] cell_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [10:0]      cursor_pos,
	output logic [15:0]      cell_data,
	output logic             scrolled,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  text_attribute
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int COPY_N = CELLS - COLUMNS;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              op_q, idx_ok_q, scroll_q;
	logic              valid_s1, copy_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        attr_q;
	logic              out_valid_q, scrolled_q;
	logic [10:0]       cursor_pos_q;
	logic [15:0]       cell_data_q;

	logic              in_accept, put_en, idx_ok, scroll_rd, load_out;
	cursor_step_t      step;
	logic [ADDR_W-1:0] cur_pos;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [15:0]       mem_wdata, mem_rdata;

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.POS_W  (ADDR_W)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.put_en   (put_en),
		.char_code(char_code),
		.step     (step),
		.cur_pos  (cur_pos)
	);

	tcw_screen_mem #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign cfg_ready  = 1'b1;
	assign in_accept  = in_valid & in_ready;
	assign put_en     = in_accept & (op_t'(op) == OP_PUT);
	assign idx_ok     = 32'(cell_index) < CELLS;
	assign scroll_rd  = (state_q == ST_SCROLL) && (cnt_q < CNT_W'(COPY_N));
	assign load_out   = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		mem_re    = scroll_rd || (in_accept && (op_t'(op) == OP_READ) && idx_ok);
		mem_raddr = scroll_rd ? ADDR_W'(cnt_q + CNT_W'(COLUMNS)) : ADDR_W'(cell_index);
		mem_we    = 1'b0;
		mem_waddr = cur_pos;
		mem_wdata = {attr_q, char_code};
		priority if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(cnt_q);
			mem_wdata = BLANK_CELL;
		end else if (valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = copy_s1 ? mem_rdata : {attr_q, BLANK_CHAR};
		end else if (put_en && step.write) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (put_en && step.scroll) ? ST_SCROLL : ST_RESP;
				end
			end
			ST_SCROLL: begin
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_SCROLL;
			if ((state_q == ST_CLEAR || state_q == ST_SCROLL) && state_d == state_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ADDR_W'(cnt_q);
		copy_s1 <= scroll_rd;
		if (in_accept) begin
			op_q     <= op;
			idx_ok_q <= idx_ok;
			scroll_q <= put_en & step.scroll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= text_attribute;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cursor_pos_q <= 11'(cur_pos);
			cell_data_q  <= (op_t'(op_q) == OP_READ && idx_ok_q) ? mem_rdata : 16'h0000;
			scrolled_q   <= scroll_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;
	assign scrolled   = scrolled_q;

endmodule

`default_nettype wire

>>> src/tcw_screen_mem.sv
`default_nettype none

module tcw_screen_mem #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [15:0]       wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/tcw_cursor.sv
`default_nettype none

module tcw_cursor
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int POS_W   = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             put_en,
	input  wire logic [7:0]       char_code,
	output cursor_step_t          step,
	output logic      [POS_W-1:0] cur_pos
);

	localparam int COL_W = $clog2(COLUMNS + (1 << TAB_SHIFT));
	localparam int ROW_W = $clog2(ROWS + 1);

	logic [COL_W-1:0] col_q, col_a, col_d, tab_col;
	logic [ROW_W-1:0] row_q, row_a, row_b, row_d;

	assign cur_pos = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	assign tab_col = ((col_q >> TAB_SHIFT) + COL_W'(1)) << TAB_SHIFT;

	always_comb begin
		col_a      = col_q;
		row_a      = row_q;
		step.write = 1'b0;
		priority if (char_code == CH_LF) begin
			col_a = '0;
			row_a = row_q + ROW_W'(1);
		end else if (char_code == CH_CR) begin
			col_a = '0;
		end else if (char_code == CH_TAB) begin
			col_a = tab_col;
		end else if (char_code >= FIRST_PRINTABLE) begin
			col_a      = col_q + COL_W'(1);
			step.write = 1'b1;
		end

		if (col_a >= COL_W'(COLUMNS)) begin
			col_d = '0;
			row_b = row_a + ROW_W'(1);
		end else begin
			col_d = col_a;
			row_b = row_a;
		end

		if (row_b >= ROW_W'(ROWS)) begin
			row_d       = ROW_W'(ROWS - 1);
			step.scroll = 1'b1;
		end else begin
			row_d       = row_b;
			step.scroll = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (put_en) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

`default_nettype wire

>>> test/text_console_writer_unit_test.sv
`default_nettype none

module text_console_writer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
		logic        scrolled;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = OP_PUT;
	logic [7:0]  char_code = '0;
	logic [10:0] cell_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;
	logic        scrolled;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  text_attribute = RESET_ATTR;

	logic [15:0]     screen_model [CELLS];
	int unsigned     cursor_row_model;
	int unsigned     cursor_col_model;
	logic [7:0]      attribute_model;
	console_result_t expected_results [$];
	console_result_t oldest_expected;
	int              error_count = 0;
	bit              no_idle = 1'b0;
	int              rx_hold_cycles = 0;

	text_console_writer_unit #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.char_code     (char_code),
		.cell_index    (cell_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_pos    (cursor_pos),
		.cell_data     (cell_data),
		.scrolled      (scrolled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.text_attribute(text_attribute)
	);

	initial begin
		forever begin
			#2 clk = ~clk;
		end
	end

	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic console_result_t apply_console_item(input op_t kind,
			input logic [7:0] ch, input logic [10:0] idx);
		console_result_t r;
		int unsigned     i;
		r = '0;
		if (kind == OP_READ) begin
			if (idx < CELLS) begin
				r.cell_data = screen_model[idx];
			end
		end else begin
			if (ch == CH_LF) begin
				cursor_col_model = 0;
				cursor_row_model++;
			end else if (ch == CH_CR) begin
				cursor_col_model = 0;
			end else if (ch == CH_TAB) begin
				cursor_col_model = ((cursor_col_model >> TAB_SHIFT) + 1) << TAB_SHIFT;
			end else if (ch >= FIRST_PRINTABLE) begin
				screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
					{attribute_model, ch};
				cursor_col_model++;
			end
			if (cursor_col_model >= COLUMNS) begin
				cursor_col_model = 0;
				cursor_row_model++;
			end
			if (cursor_row_model >= ROWS) begin
				for (i = 0; i < CELLS - COLUMNS; i++) begin
					screen_model[i] = screen_model[i + COLUMNS];
				end
				for (i = CELLS - COLUMNS; i < CELLS; i++) begin
					screen_model[i] = {attribute_model, BLANK_CHAR};
				end
				cursor_row_model = ROWS - 1;
				r.scrolled = 1'b1;
			end
		end
		r.cursor_pos = 11'(cursor_row_model * COLUMNS + cursor_col_model);
		return r;
	endfunction

	task automatic send_item(input op_t kind, input logic [7:0] ch, input logic [10:0] idx);
		while (!no_idle && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		char_code  <= ch;
		cell_index <= idx;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(apply_console_item(kind, ch, idx));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_attribute(input logic [7:0] value);
		wait_for_results();
		cfg_valid      <= 1'b1;
		text_attribute <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid       <= 1'b0;
		attribute_model = value;
	endtask

	task automatic send_random_item();
		logic [7:0]  ch;
		logic [10:0] idx;
		int unsigned roll;
		ch   = 8'($urandom);
		idx  = 11'($urandom);
		roll = $urandom_range(99);
		if (roll < 15) begin
			idx = 11'(cursor_row_model * COLUMNS + $urandom_range(COLUMNS - 1));
			send_item(OP_READ, ch, idx);
		end else if (roll < 40) begin
			if ($urandom_range(19) != 0) begin
				idx = 11'($urandom_range(CELLS - 1));
			end
			send_item(OP_READ, ch, idx);
		end else begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				ch = CH_LF;
			end else if (roll < 9) begin
				ch = CH_TAB;
			end else if (roll < 11) begin
				ch = CH_CR;
			end else if (roll < 15) begin
				ch = 8'($urandom_range(FIRST_PRINTABLE - 1));
			end else begin
				ch = 8'($urandom_range(255, FIRST_PRINTABLE));
			end
			send_item(OP_PUT, ch, idx);
		end
	endtask

	task automatic test_cleared_screen();
		send_item(OP_READ, 8'h00, 11'd0);
		send_item(OP_READ, 8'hFF, 11'(CELLS - 1));
		send_item(OP_READ, 8'h00, 11'(CELLS));
		send_item(OP_READ, 8'hFF, 11'h7FF);
	endtask

	task automatic test_attribute_extremes();
		write_attribute(8'h00);
		send_item(OP_PUT, 8'h41, 11'h7FF);
		write_attribute(8'hFF);
		send_item(OP_PUT, 8'hFF, 11'h000);
		send_item(OP_PUT, 8'h7F, 11'h000);
		send_item(OP_PUT, FIRST_PRINTABLE, 11'h000);
		send_item(OP_READ, 8'h00, 11'd0);
		send_item(OP_READ, 8'h00, 11'd1);
		send_item(OP_READ, 8'h00, 11'd2);
	endtask

	task automatic test_control_codes();
		send_item(OP_PUT, CH_CR, 11'h000);
		send_item(OP_PUT, 8'h78, 11'h000);
		send_item(OP_PUT, CH_TAB, 11'h000);
		send_item(OP_PUT, 8'h00, 11'h000);
		send_item(OP_PUT, 8'h1F, 11'h000);
		send_item(OP_PUT, 8'h1B, 11'h000);
		send_item(OP_PUT, CH_LF, 11'h000);
	endtask

	task automatic test_scroll_on_last_row();
		while (cursor_row_model < ROWS - 1) begin
			send_item(OP_PUT, CH_LF, 11'h000);
		end
		send_item(OP_PUT, CH_LF, 11'h000);
		repeat (COLUMNS / 8) begin
			send_item(OP_PUT, CH_TAB, 11'h000);
		end
		send_item(OP_READ, 8'h00, 11'(CELLS - COLUMNS));
	endtask

	task automatic test_output_stall();
		rx_hold_cycles = 400;
		repeat (30) begin
			send_random_item();
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) begin
			send_random_item();
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 14);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("Result with no item outstanding: cursor_pos %0d, cell_data %h",
					cursor_pos, cell_data);
				error_count++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (cursor_pos !== oldest_expected.cursor_pos) begin
					$error("cursor_pos mismatch: expected %0d, actual %0d",
						oldest_expected.cursor_pos, cursor_pos);
					error_count++;
				end
				if (cell_data !== oldest_expected.cell_data) begin
					$error("cell_data mismatch: expected %h, actual %h",
						oldest_expected.cell_data, cell_data);
					error_count++;
				end
				if (scrolled !== oldest_expected.scrolled) begin
					$error("scrolled mismatch: expected %0d, actual %0d",
						oldest_expected.scrolled, scrolled);
					error_count++;
				end
			end
		end
	end

	initial begin
		attribute_model  = RESET_ATTR;
		cursor_row_model = 0;
		cursor_col_model = 0;
		for (int i = 0; i < CELLS; i++) begin
			screen_model[i] = {RESET_ATTR, BLANK_CHAR};
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_screen();
		test_attribute_extremes();
		test_control_codes();
		test_scroll_on_last_row();
		test_output_stall();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				write_attribute(RESET_ATTR);
			end else if (phase == 5) begin
				write_attribute(8'hFF);
			end else begin
				write_attribute(8'($urandom));
			end
			no_idle = (phase == 2);
			test_random_traffic(300);
		end
		no_idle = 1'b0;

		wait_for_results();
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
